FILE: hdl/utf8_to_utf16_transcoder_unit_defines.svh
// Assertion macros shared by the transcoder RTL.
// U2U_ASSERT_IMPL: antecedent implies consequent in the same cycle.
// U2U_ASSERT_NEVER: condition must never hold.
`ifndef UTF8_TO_UTF16_TRANSCODER_UNIT_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define U2U_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);
`define U2U_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
    else $error(msg);
`else
`define U2U_ASSERT_IMPL(lbl, clk, rstn, ante, cons, msg)
`define U2U_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: hdl/u2u_pkg.sv
`default_nettype none
package u2u_pkg;

  // byte classification limits
  localparam logic [7:0] LEAD_MIN      = 8'hC2;
  localparam logic [7:0] LEAD3_MIN     = 8'hE0;
  localparam logic [7:0] LEAD4_MIN     = 8'hF0;
  localparam logic [7:0] LEAD_MAX      = 8'hF4;
  localparam logic [7:0] LEAD_E0       = 8'hE0;
  localparam logic [7:0] LEAD_ED       = 8'hED;
  localparam logic [7:0] LEAD_F0       = 8'hF0;
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;

  // code point limits
  localparam int unsigned CP_W = 21;
  localparam logic [CP_W-1:0] BMP_MAX   = 21'h00FFFF;
  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [15:0] REPL_CHAR = 16'hFFFD;
  localparam logic [15:0] HI_SURR   = 16'hD800;
  localparam logic [15:0] LO_SURR   = 16'hDC00;

  // what the back end has to produce for one queued entry
  typedef enum logic [1:0] {
    K_UNIT = 2'd0,
    K_PAIR = 2'd1,
    K_ERR  = 2'd2
  } u2u_kind_t;

  typedef struct packed {
    u2u_kind_t       kind;
    logic [CP_W-1:0] cp;
    logic            last;
  } u2u_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } u2u_qstat_t;

endpackage
`default_nettype wire

FILE: hdl/u2u_front.sv
`default_nettype none
`include "utf8_to_utf16_transcoder_unit_defines.svh"
module u2u_front
  import u2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_data,
  input  wire logic       in_valid,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_string_last,
  output logic            in_stall,
  input  wire u2u_qstat_t qstat,
  output logic            push,
  output u2u_entry_t      entry
);

  logic            strict_r;
  logic [CP_W-1:0] code_accum_r, code_accum_nxt;
  logic [1:0]      bytes_left_r, bytes_left_nxt;
  logic [7:0]      lead_value_r, lead_value_nxt;
  logic            awaiting_second_r, awaiting_second_nxt;
  logic            discarding_r, discarding_nxt;

  logic            in_acc;
  logic            ok;
  logic            fail;
  logic            emit;
  logic [CP_W-1:0] emit_cp;
  logic [CP_W-1:0] acc_shift;

  assign in_stall = qstat.full;
  assign in_acc   = in_valid && !qstat.full;
  assign acc_shift = {code_accum_r[CP_W-7:0], in_byte[5:0]};

  // decode one byte against the partial sequence
  always_comb begin
    code_accum_nxt      = code_accum_r;
    bytes_left_nxt      = bytes_left_r;
    lead_value_nxt      = lead_value_r;
    awaiting_second_nxt = awaiting_second_r;
    discarding_nxt      = discarding_r;
    push       = 1'b0;
    entry.kind = K_UNIT;
    entry.cp   = '0;
    entry.last = in_string_last;
    ok      = 1'b0;
    fail    = 1'b0;
    emit    = 1'b0;
    emit_cp = '0;
    if (in_acc) begin
      if (discarding_r) begin
        if (in_string_last) begin
          discarding_nxt = 1'b0;
        end
      end else if (bytes_left_r == 2'd0) begin
        if (!in_byte[7]) begin
          emit    = 1'b1;
          emit_cp = {{(CP_W-8){1'b0}}, in_byte};
        end else if (in_byte < LEAD_MIN || in_byte > LEAD_MAX) begin
          fail = 1'b1;
        end else begin
          priority if (in_byte < LEAD3_MIN) begin
            bytes_left_nxt = 2'd1;
            code_accum_nxt = {{(CP_W-5){1'b0}}, in_byte[4:0]};
          end else if (in_byte < LEAD4_MIN) begin
            bytes_left_nxt = 2'd2;
            code_accum_nxt = {{(CP_W-4){1'b0}}, in_byte[3:0]};
          end else begin
            bytes_left_nxt = 2'd3;
            code_accum_nxt = {{(CP_W-3){1'b0}}, in_byte[2:0]};
          end
          lead_value_nxt      = in_byte;
          awaiting_second_nxt = 1'b1;
          if (in_string_last) begin
            fail = 1'b1;
          end
        end
      end else begin
        ok = (in_byte[7:6] == 2'b10);
        if (awaiting_second_r) begin
          if (lead_value_r == LEAD_E0 && in_byte < E0_SECOND_MIN) ok = 1'b0;
          if (lead_value_r == LEAD_ED && in_byte > ED_SECOND_MAX) ok = 1'b0;
          if (lead_value_r == LEAD_F0 && in_byte < F0_SECOND_MIN) ok = 1'b0;
        end
        if (!ok) begin
          fail = 1'b1;
        end else begin
          code_accum_nxt      = acc_shift;
          bytes_left_nxt      = bytes_left_r - 2'd1;
          awaiting_second_nxt = 1'b0;
          if (bytes_left_r != 2'd1) begin
            if (in_string_last) begin
              fail = 1'b1;
            end
          end else begin
            emit    = 1'b1;
            emit_cp = acc_shift;
          end
        end
      end

      // completed code point
      if (emit) begin
        code_accum_nxt      = '0;
        bytes_left_nxt      = 2'd0;
        lead_value_nxt      = '0;
        awaiting_second_nxt = 1'b0;
        if (emit_cp > CP_MAX) begin
          if (strict_r) begin
            fail = 1'b1;
          end else begin
            push     = 1'b1;
            entry.cp = {{(CP_W-16){1'b0}}, REPL_CHAR};
          end
        end else begin
          push       = 1'b1;
          entry.cp   = emit_cp;
          entry.kind = (emit_cp > BMP_MAX) ? K_PAIR : K_UNIT;
        end
      end

      // malformed: one error result, then drop to string end
      if (fail) begin
        code_accum_nxt      = '0;
        bytes_left_nxt      = 2'd0;
        lead_value_nxt      = '0;
        awaiting_second_nxt = 1'b0;
        discarding_nxt      = !in_string_last;
        push       = 1'b1;
        entry.kind = K_ERR;
        entry.cp   = '0;
        entry.last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strict_r          <= 1'b0;
      code_accum_r      <= '0;
      bytes_left_r      <= 2'd0;
      lead_value_r      <= '0;
      awaiting_second_r <= 1'b0;
      discarding_r      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        strict_r <= cfg_data;
      end
      code_accum_r      <= code_accum_nxt;
      bytes_left_r      <= bytes_left_nxt;
      lead_value_r      <= lead_value_nxt;
      awaiting_second_r <= awaiting_second_nxt;
      discarding_r      <= discarding_nxt;
    end
  end

  // discard mode never overlaps a sequence in progress
  `U2U_ASSERT_IMPL(a_discard_no_seq, clk, rst_n, discarding_r, bytes_left_r == 2'd0,
                   "discarding with a sequence in progress")

endmodule
`default_nettype wire

FILE: hdl/u2u_queue.sv
`default_nettype none
`include "utf8_to_utf16_transcoder_unit_defines.svh"
module u2u_queue
  import u2u_pkg::*;
#(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  wire u2u_entry_t wr_entry,
  input  wire logic       pop,
  output u2u_entry_t      rd_entry,
  output u2u_qstat_t      qstat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  u2u_entry_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign qstat.full  = (count_r == CNT_W'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign rd_entry    = mem_r[rd_ptr_r];

  // pointer and fill level update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

  `U2U_ASSERT_NEVER(a_no_overflow, clk, rst_n, push && qstat.full,
                    "queue written while full")
  `U2U_ASSERT_NEVER(a_no_underflow, clk, rst_n, pop && qstat.empty,
                    "queue read while empty")

endmodule
`default_nettype wire

FILE: hdl/u2u_back.sv
`default_nettype none
`include "utf8_to_utf16_transcoder_unit_defines.svh"
module u2u_back
  import u2u_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire u2u_entry_t head,
  input  wire u2u_qstat_t qstat,
  output logic            pop,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [15:0]     out_code_unit,
  output logic            out_is_error,
  output logic            out_ends_string,
  output logic            out_item_last
);

  logic        out_valid_r, out_valid_nxt;
  logic        pend_r, pend_nxt;
  logic [15:0] unit_r, unit_nxt;
  logic        err_r, err_nxt;
  logic        ends_r, ends_nxt;
  logic        ilast_r, ilast_nxt;
  logic [15:0] low_r, low_nxt;
  logic        low_ends_r, low_ends_nxt;

  logic            out_free;
  logic [CP_W-1:0] supp;
  logic [15:0]     hi_unit;
  logic [15:0]     lo_unit;

  assign out_free = !out_valid_r || !out_stall;
  assign pop      = out_free && !pend_r && !qstat.empty;

  // surrogate split of the head entry
  assign supp    = head.cp - SUPP_BASE;
  assign hi_unit = HI_SURR + {6'b0, supp[19:10]};
  assign lo_unit = LO_SURR + {6'b0, supp[9:0]};

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    unit_nxt      = unit_r;
    err_nxt       = err_r;
    ends_nxt      = ends_r;
    ilast_nxt     = ilast_r;
    low_nxt       = low_r;
    low_ends_nxt  = low_ends_r;
    if (out_free) begin
      if (pend_r) begin
        // second half of a surrogate pair
        out_valid_nxt = 1'b1;
        pend_nxt      = 1'b0;
        unit_nxt      = low_r;
        err_nxt       = 1'b0;
        ends_nxt      = low_ends_r;
        ilast_nxt     = 1'b1;
      end else if (!qstat.empty) begin
        out_valid_nxt = 1'b1;
        unique case (head.kind)
          K_PAIR: begin
            pend_nxt     = 1'b1;
            unit_nxt     = hi_unit;
            err_nxt      = 1'b0;
            ends_nxt     = 1'b0;
            ilast_nxt    = 1'b0;
            low_nxt      = lo_unit;
            low_ends_nxt = head.last;
          end
          K_ERR: begin
            unit_nxt  = '0;
            err_nxt   = 1'b1;
            ends_nxt  = 1'b1;
            ilast_nxt = 1'b1;
          end
          default: begin
            unit_nxt  = head.cp[15:0];
            err_nxt   = 1'b0;
            ends_nxt  = head.last;
            ilast_nxt = 1'b1;
          end
        endcase
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    unit_r     <= unit_nxt;
    err_r      <= err_nxt;
    ends_r     <= ends_nxt;
    ilast_r    <= ilast_nxt;
    low_r      <= low_nxt;
    low_ends_r <= low_ends_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_code_unit   = unit_r;
  assign out_is_error    = err_r;
  assign out_ends_string = ends_r;
  assign out_item_last   = ilast_r;

  // a non-final result is always the high half with its low half held back
  `U2U_ASSERT_IMPL(a_pair_pending, clk, rst_n, out_valid_r && !ilast_r, pend_r,
                   "non-final result without pending low surrogate")
  `U2U_ASSERT_IMPL(a_err_shape, clk, rst_n, out_valid_r && err_r,
                   ends_r && ilast_r && (unit_r == 16'h0000),
                   "error result with bad fields")

endmodule
`default_nettype wire

FILE: hdl/utf8_to_utf16_transcoder_unit.sv
`default_nettype none
// UTF-8 to UTF-16 transcoder.
// Input channel (in_valid / in_stall): one UTF-8 byte per transfer, with
// in_string_last on the final byte of a string. A transfer happens at a
// clock edge with in_valid high and in_stall low.
// Output channel (out_valid / out_stall): one UTF-16 code unit per transfer,
// with flags for error, end of string and last result of the input byte.
// A malformed string gives one error result; its remaining bytes are dropped.
// Config (cfg_valid / cfg_ready): cfg_data sets strict mode; cfg_ready is
// always high. Write it only while the block is idle.
// Path: a taken byte is decoded straight into the queue, and its result then
// passes from the queue to the output register. Throughput: one byte per
// cycle while in_stall is low; a surrogate pair gives two results from one
// queue entry, which the queue of QUEUE_DEPTH entries absorbs.
// When the receiver stalls, the output register holds and the queue fills;
// in_stall rises once the queue is full.
// Reset (rst_n, synchronous, active low) clears strict mode, the partial
// sequence, the discard state, the queue and the output valid and pending flags.
module utf8_to_utf16_transcoder_unit
  import u2u_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_string_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      out_code_unit,
  output logic             out_is_error,
  output logic             out_ends_string,
  output logic             out_item_last
);

  u2u_qstat_t qstat;
  u2u_entry_t wr_entry;
  u2u_entry_t head;
  logic       push;
  logic       pop;

  assign cfg_ready = 1'b1;

  u2u_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_byte        (in_byte),
    .in_string_last (in_string_last),
    .in_stall       (in_stall),
    .qstat          (qstat),
    .push           (push),
    .entry          (wr_entry)
  );

  u2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (head),
    .qstat    (qstat)
  );

  u2u_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .qstat           (qstat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_is_error    (out_is_error),
    .out_ends_string (out_ends_string),
    .out_item_last   (out_item_last)
  );

endmodule
`default_nettype wire

FILE: test/u2u_transcode_monitor.sv
// Watches the byte, result and config channels of the transcoder, predicts
// the UTF-16 results of every accepted byte and compares each result
// transfer against the oldest prediction.
module u2u_transcode_monitor
  import u2u_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_string_last,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_code_unit,
  input  logic        out_is_error,
  input  logic        out_ends_string,
  input  logic        out_item_last,
  output int          mismatches,
  output int          results_pending
);

  typedef struct packed {
    logic [15:0] code_unit;
    logic        is_error;
    logic        ends_string;
    logic        item_last;
  } utf16_result_t;

  utf16_result_t expected_units[$];

  // predicted decoder state
  logic        strict_mode;
  logic [20:0] partial_cp;
  logic [1:0]  cont_left;
  logic [7:0]  lead_byte;
  logic        second_due;
  logic        dropping;

  function automatic void clear_sequence();
    partial_cp = '0;
    cont_left  = '0;
    lead_byte  = '0;
    second_due = 1'b0;
  endfunction

  function automatic void expect_unit(logic [15:0] unit, logic err, logic ends, logic ilast);
    utf16_result_t r;
    r.code_unit   = unit;
    r.is_error    = err;
    r.ends_string = ends;
    r.item_last   = ilast;
    expected_units.insert(expected_units.size(), r);
  endfunction

  // malformed string: one error result, then drop up to the string end
  function automatic void expect_error(logic last);
    clear_sequence();
    dropping = !last;
    expect_unit(16'h0000, 1'b1, 1'b1, 1'b1);
  endfunction

  function automatic void expect_code_point(logic [20:0] cp, logic last);
    logic [20:0] offset;
    clear_sequence();
    if (cp <= BMP_MAX) begin
      expect_unit(cp[15:0], 1'b0, last, 1'b1);
    end else if (cp > CP_MAX) begin
      if (strict_mode) begin
        expect_error(last);
      end else begin
        expect_unit(REPL_CHAR, 1'b0, last, 1'b1);
      end
    end else begin
      // surrogate pair; first unit never closes the string or the byte
      offset = cp - SUPP_BASE;
      expect_unit(HI_SURR + {6'b0, offset[19:10]}, 1'b0, 1'b0, 1'b0);
      expect_unit(LO_SURR + {6'b0, offset[9:0]}, 1'b0, last, 1'b1);
    end
  endfunction

  function automatic void decode_utf8_byte(logic [7:0] b, logic last);
    logic ok;
    if (dropping) begin
      if (last) dropping = 1'b0;
      return;
    end

    // lead byte
    if (cont_left == 2'd0) begin
      if (b < 8'h80) begin
        expect_code_point({13'b0, b}, last);
        return;
      end
      if (b < LEAD_MIN || b > LEAD_MAX) begin
        expect_error(last);
        return;
      end
      if (b < LEAD3_MIN) begin
        cont_left  = 2'd1;
        partial_cp = {16'b0, b[4:0]};
      end else if (b < LEAD4_MIN) begin
        cont_left  = 2'd2;
        partial_cp = {17'b0, b[3:0]};
      end else begin
        cont_left  = 2'd3;
        partial_cp = {18'b0, b[2:0]};
      end
      lead_byte  = b;
      second_due = 1'b1;
      if (last) expect_error(last);
      return;
    end

    // continuation byte, with the tighter second-byte ranges
    ok = (b >= 8'h80 && b <= 8'hBF);
    if (second_due) begin
      if (lead_byte == LEAD_E0 && b < E0_SECOND_MIN) ok = 1'b0;
      if (lead_byte == LEAD_ED && b > ED_SECOND_MAX) ok = 1'b0;
      if (lead_byte == LEAD_F0 && b < F0_SECOND_MIN) ok = 1'b0;
    end
    if (!ok) begin
      expect_error(last);
      return;
    end

    partial_cp = {partial_cp[14:0], b[5:0]};
    cont_left  = cont_left - 2'd1;
    second_due = 1'b0;
    if (cont_left != 2'd0) begin
      if (last) expect_error(last);
      return;
    end
    expect_code_point(partial_cp, last);
  endfunction

  // track config, predict on byte transfers, check result transfers
  always @(posedge clk) begin
    utf16_result_t want;
    if (!rst_n) begin
      strict_mode = 1'b0;
      dropping    = 1'b0;
      clear_sequence();
      expected_units.delete();
    end else begin
      if (cfg_valid && cfg_ready) strict_mode = cfg_data;
      if (in_valid && !in_stall) decode_utf8_byte(in_byte, in_string_last);
      if (out_valid && !out_stall) begin
        if (expected_units.size() == 0) begin
          $error("unexpected result: code_unit %h is_error %b ends_string %b item_last %b",
                 out_code_unit, out_is_error, out_ends_string, out_item_last);
          mismatches++;
        end else begin
          want = expected_units.pop_front();
          if (out_code_unit !== want.code_unit) begin
            $error("code_unit: expected %h, got %h", want.code_unit, out_code_unit);
            mismatches++;
          end
          if (out_is_error !== want.is_error) begin
            $error("is_error: expected %b, got %b", want.is_error, out_is_error);
            mismatches++;
          end
          if (out_ends_string !== want.ends_string) begin
            $error("ends_string: expected %b, got %b", want.ends_string, out_ends_string);
            mismatches++;
          end
          if (out_item_last !== want.item_last) begin
            $error("item_last: expected %b, got %b", want.item_last, out_item_last);
            mismatches++;
          end
        end
      end
    end
    results_pending <= expected_units.size();
  end

endmodule

FILE: test/utf8_to_utf16_transcoder_unit_tb.sv
// Stimulus and verdict for the transcoder: directed strings, then random
// well-formed, broken and noise strings in both strict and lax mode.
module utf8_to_utf16_transcoder_unit_tb;

  localparam int IDLE_LIMIT    = 1000;
  localparam int PHASE_BYTES   = 420;
  localparam int SETTLE_CYCLES = 8;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic        cfg_data       = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [7:0]  in_byte        = 8'h00;
  logic        in_string_last = 1'b0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [15:0] out_code_unit;
  logic        out_is_error;
  logic        out_ends_string;
  logic        out_item_last;

  int          fail_count;
  int          results_pending;
  logic        no_idle      = 1'b0;
  int          stall_left   = 0;
  int          idle_cycles  = 0;
  logic [7:0]  str_bytes[$];

  always #5 clk = ~clk;

  utf8_to_utf16_transcoder_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_string_last  (in_string_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_is_error    (out_is_error),
    .out_ends_string (out_ends_string),
    .out_item_last   (out_item_last)
  );

  u2u_transcode_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_string_last  (in_string_last),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_code_unit   (out_code_unit),
    .out_is_error    (out_is_error),
    .out_ends_string (out_ends_string),
    .out_item_last   (out_item_last),
    .mismatches      (fail_count),
    .results_pending (results_pending)
  );

  // wait before a transfer; zero throughout a no-idle stretch
  function automatic int draw_wait();
    if (no_idle) return 0;
    if ($urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 18);
  endfunction

  // receiver: after each result transfer, stall for a random count
  always @(posedge clk) begin
    int w;
    if (!rst_n) begin
      stall_left <= 0;
      out_stall  <= 1'b0;
    end else if (out_valid && !out_stall) begin
      w = draw_wait();
      stall_left <= w;
      out_stall  <= (w != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left > 1);
    end
  end

  // watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles == IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_byte        <= b;
    in_string_last <= last;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_string();
    foreach (str_bytes[i]) send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // hold the sender until every predicted result has been seen
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_strict(input logic mode);
    cfg_valid <= 1'b1;
    cfg_data  <= mode;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [20:0] pick_code_point();
    case ($urandom_range(0, 9))
      0, 1, 2: return 21'($urandom_range(0, 21'h7F));
      3:       return 21'($urandom_range(21'h80, 21'h7FF));
      4:       return 21'($urandom_range(21'h800, 21'hFFFF));
      5, 6:    return 21'($urandom_range(21'h10000, 21'h10FFFF));
      7:       return 21'($urandom_range(21'h110000, 21'h13FFFF));
      default: begin
        // boundaries of each encoding length and of the surrogate gap
        case ($urandom_range(0, 11))
          0:       return 21'h00007F;
          1:       return 21'h000080;
          2:       return 21'h0007FF;
          3:       return 21'h000800;
          4:       return 21'h00D7FF;
          5:       return 21'h00E000;
          6:       return 21'h00FFFD;
          7:       return 21'h00FFFF;
          8:       return 21'h010000;
          9:       return 21'h10FFFF;
          10:      return 21'h110000;
          default: return 21'h13FFFF;
        endcase
      end
    endcase
  endfunction

  // append one byte to the string under construction
  function automatic void add_byte(logic [7:0] b);
    str_bytes.insert(str_bytes.size(), b);
  endfunction

  function automatic void append_utf8(logic [20:0] cp);
    if (cp < 21'h80) begin
      add_byte(cp[7:0]);
    end else if (cp < 21'h800) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp < 21'h10000) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // mostly well-formed strings; some broken, some random noise
  function automatic void build_string();
    int n;
    int idx;
    int kind;
    str_bytes.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      n = $urandom_range(1, 6);
      repeat (n) add_byte(8'($urandom_range(0, 255)));
      return;
    end
    n = $urandom_range(1, 5);
    repeat (n) append_utf8(pick_code_point());
    if (kind != 1) return;
    case ($urandom_range(0, 2))
      0: begin
        // truncate inside the string
        if (str_bytes.size() > 1) begin
          idx = $urandom_range(1, str_bytes.size() - 1);
          repeat (idx) void'(str_bytes.pop_back());
        end
      end
      1: begin
        idx = $urandom_range(0, str_bytes.size() - 1);
        str_bytes[idx] = 8'($urandom_range(0, 255));
      end
      default: begin
        idx = $urandom_range(0, str_bytes.size());
        str_bytes.insert(idx, 8'($urandom_range(0, 255)));
      end
    endcase
  endfunction

  initial begin
    int sent;
    int phase;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // lax mode: ASCII extremes, shortest/longest forms, max code point pair
    write_strict(1'b0);
    str_bytes = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hEF, 8'hBF, 8'hBF,
                  8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_string();
    // above 0x10FFFF becomes the replacement char
    str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_string();
    // second byte below the E0 limit, rest of the string dropped
    str_bytes = '{8'hE0, 8'h9F, 8'h41};
    send_string();
    // illegal lead
    str_bytes = '{8'hFF};
    send_string();
    // continuation below 0x80
    str_bytes = '{8'hC2, 8'h41};
    send_string();
    // truncated at string end
    str_bytes = '{8'hE1, 8'h80};
    send_string();
    wait_results_drained();

    // strict mode: above 0x10FFFF is an error
    write_strict(1'b1);
    str_bytes = '{8'hF4, 8'h90, 8'h80, 8'h80};
    send_string();

    // random phases alternating the mode; third phase runs without idling
    for (phase = 0; phase < 4; phase++) begin
      wait_results_drained();
      write_strict(phase[0]);
      no_idle <= (phase == 2);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_string();
        sent += str_bytes.size();
        send_string();
        if ($urandom_range(0, 60) == 0) wait_results_drained();
      end
    end

    wait_results_drained();
    if (fail_count == 0 && results_pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
